### rtl/dwmc_pkg.sv
// Shared types, register codes and symbol-compare functions for the diagonal
// window match counter.
// No dependencies; dwmc_match, dwmc_window and the top level import this package.
package dwmc_pkg;

	// Field widths fixed by the interface
	localparam int unsigned IN_COORD_W = 20;
	localparam int unsigned OUT_COORD_W = 21;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 7;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MODE = 2'd2;

	// Register reset values
	localparam logic [6:0] WINDOW_LEN_RST = 7'd20;
	localparam logic [6:0] MATCH_THRESHOLD_RST = 7'd16;

	// Compare modes; the unused code never matches
	localparam logic [1:0] MODE_NUC = 2'd0;
	localparam logic [1:0] MODE_AMINO = 2'd1;
	localparam logic [1:0] MODE_REVCOMP = 2'd2;

	localparam logic [SYM_W-1:0] SYM_N = "N";

	typedef struct packed {
		logic                  diag_first;
		logic [IN_COORD_W-1:0] start_a;
		logic [IN_COORD_W-1:0] start_b;
		logic [SYM_W-1:0]      sym_a;
		logic [SYM_W-1:0]      sym_b;
	} in_word_t;

	typedef struct packed {
		logic [OUT_COORD_W-1:0] a_begin;
		logic [OUT_COORD_W-1:0] b_begin;
		logic [OUT_COORD_W-1:0] a_end;
		logic [OUT_COORD_W-1:0] b_end;
	} out_word_t;

	// Per-word control from the top level into the window chain
	typedef struct packed {
		logic step;
		logic clear;
		logic hit;
	} win_ctrl_t;

	typedef enum logic [2:0] {
		CLS_L,
		CLS_S,
		CLS_F,
		CLS_D,
		CLS_K,
		CLS_C,
		CLS_X
	} aa_class_t;

	// Amino-acid similarity class; anything unlisted falls in class X
	function automatic aa_class_t aa_class(input logic [SYM_W-1:0] s);
		aa_class_t c;
		case (s) inside
			"L", "I", "M", "V":      c = CLS_L;
			"S", "P", "T", "A", "G": c = CLS_S;
			"F", "Y", "W":           c = CLS_F;
			"D", "E", "N", "Q":      c = CLS_D;
			"K", "R", "H":           c = CLS_K;
			"C":                     c = CLS_C;
			default:                 c = CLS_X;
		endcase
		return c;
	endfunction

	// Watson-Crick complement check; non-ACGT first symbols never match
	function automatic logic comp_match(input logic [SYM_W-1:0] a, input logic [SYM_W-1:0] b);
		logic m;
		case (a)
			"A":     m = (b == "T");
			"T":     m = (b == "A");
			"G":     m = (b == "C");
			"C":     m = (b == "G");
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	// Effective window length: zero reads as one, clamp to the cell count
	function automatic logic [8:0] eff_len(input logic [6:0] wl, input int unsigned max_w);
		logic [8:0] l;
		l = {2'b00, wl};
		if (l == 9'd0) begin
			l = 9'd1;
		end
		if (l > 9'(max_w)) begin
			l = 9'(max_w);
		end
		return l;
	endfunction

endpackage

### rtl/dwmc_match.sv
// Symbol-pair compare for the three match modes.
// Depends on dwmc_pkg (class and complement functions, mode codes).
module dwmc_match (
	input  logic [dwmc_pkg::SYM_W-1:0] sym_a,
	input  logic [dwmc_pkg::SYM_W-1:0] sym_b,
	input  logic [1:0]                 mode,
	output logic                       hit
);
	import dwmc_pkg::*;

	// Select the rule for the current mode
	always_comb begin
		case (mode)
			MODE_NUC:     hit = (sym_a == sym_b) && (sym_a != SYM_N);
			MODE_AMINO:   hit = (aa_class(sym_a) == aa_class(sym_b));
			MODE_REVCOMP: hit = comp_match(sym_a, sym_b);
			default:      hit = 1'b0;
		endcase
	end

endmodule

### rtl/dwmc_cell.sv
// One cell of the match-bit chain: holds one window bit, hands it on each
// shift, and flags it when it sits at the window's oldest position.
// Depends on nothing.
module dwmc_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned LW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          clear,
	input  logic          din,
	input  logic [LW-1:0] len_m1,
	output logic          q,
	output logic          tail
);

	// Take the neighbour's bit, or drop to zero on a new diagonal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= 1'b0;
		end else if (load) begin
			q <= clear ? 1'b0 : din;
		end
	end

	// Offer the bit that leaves the window on the next shift
	assign tail = q && (len_m1 == LW'(IDX));

endmodule

### rtl/dwmc_window.sv
// Sliding match window: chain of dwmc_cell, running match count, fill count
// and the recount sweep that follows a window shrink.
// Depends on dwmc_pkg (win_ctrl_t) and dwmc_cell.
module dwmc_window #(
	parameter int unsigned MAX_WINDOW = 64,
	localparam int unsigned LW = $clog2(MAX_WINDOW + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dwmc_pkg::win_ctrl_t ctrl,
	input  logic [LW-1:0]       len,
	input  logic [6:0]          thr,
	input  logic                len_wr,
	input  logic [LW-1:0]       len_new,
	output logic                busy,
	output logic                report
);
	import dwmc_pkg::*;

	localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [MAX_WINDOW-1:0] ring;
	logic [MAX_WINDOW-1:0] tail;
	logic [LW-1:0]         count_q;
	logic [LW-1:0]         fill_q;
	logic [LW-1:0]         remain_q;
	logic [LW-1:0]         count_nx;
	logic [LW-1:0]         fill_nx;
	logic [LW-1:0]         len_m1;
	logic [LW-1:0]         orig_idx;
	logic [PW-1:0]         phase_q;
	logic [PW-1:0]         phase_nx;
	logic                  busy_q;
	logic                  shift_en;
	logic                  drop;
	logic                  sweep_take;
	logic                  restart;

	assign len_m1 = len - LW'(1);
	assign shift_en = ctrl.step || busy_q;

	// Cell chain: cell 0 takes the new match bit, or the top bit while rotating
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic din;
		if (i == 0) begin : g_head
			assign din = busy_q ? ring[MAX_WINDOW-1] : ctrl.hit;
		end else begin : g_body
			assign din = ring[i-1];
		end
		dwmc_cell #(
			.IDX (i),
			.LW  (LW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (shift_en),
			.clear  (ctrl.step && ctrl.clear && (i != 0)),
			.din    (din),
			.len_m1 (len_m1),
			.q      (ring[i]),
			.tail   (tail[i])
		);
	end

	// Slide the count: add the new bit, drop the oldest once the window is full
	assign drop = (fill_q == len) && (|tail);

	always_comb begin
		if (ctrl.clear) begin
			count_nx = LW'(ctrl.hit);
			fill_nx = LW'(1);
		end else begin
			count_nx = count_q + LW'(ctrl.hit) - LW'(drop);
			fill_nx = (fill_q == len) ? fill_q : fill_q + LW'(1);
		end
	end

	assign report = ctrl.step && (fill_nx == len) && ({2'b00, thr} <= 9'(count_nx));

	// Recount: rotate the chain once round and count bits below the new fill
	assign phase_nx = (phase_q == PW'(MAX_WINDOW - 1)) ? '0 : phase_q + PW'(1);
	assign orig_idx = LW'(MAX_WINDOW - 1) - LW'(phase_q);
	assign sweep_take = ring[MAX_WINDOW-1] && (orig_idx < fill_q) && (remain_q != '0);
	assign restart = len_wr && (fill_q > len_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fill_q <= '0;
			remain_q <= '0;
			phase_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (restart) begin
				fill_q <= len_new;
				count_q <= '0;
				remain_q <= LW'(MAX_WINDOW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				count_q <= count_q + LW'(sweep_take);
				if (remain_q != '0) begin
					remain_q <= remain_q - LW'(1);
				end
				if ((remain_q <= LW'(1)) && (phase_nx == '0)) begin
					busy_q <= 1'b0;
				end
			end else if (ctrl.step) begin
				count_q <= count_nx;
				fill_q <= fill_nx;
			end
			if (busy_q) begin
				phase_q <= phase_nx;
			end
		end
	end

	assign busy = busy_q;

	// The count covers only bits inside the fill
	a_count_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fill_q)
		else $error("match count exceeds fill count");

	// Outside a recount the fill never passes the window length
	a_fill_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (fill_q <= len))
		else $error("fill count beyond window length");

	// A recount leaves the chain in its original orientation
	a_sweep_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (phase_q == '0))
		else $error("recount ended with the chain rotated");

endmodule

### rtl/diagonal_window_match_counter.sv
// Top level of the diagonal window match counter: configuration registers,
// coordinate tracking, result stage and output register.
// Depends on dwmc_pkg, dwmc_match and dwmc_window.
//
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+-----------------------------
//  in       | in        | in_valid / in_ready  | in_data  (dwmc_pkg::in_word_t)
//  out      | out       | out_valid / out_ready| out_data (dwmc_pkg::out_word_t)
//  cfg      | in        | cfg_wen              | cfg_idx, cfg_wdata
//
// One symbol pair per cycle while in_ready is high; a hit passes from the edge that takes
// its pair through the result stage and the output register to out_valid.
// A window_len write that cuts the current fill starts a recount that rotates
// the cell chain once round (further if rewritten meanwhile) with in_ready low;
// writes are taken throughout.
// A stalled output holds its word; the coordinate stage still takes one more hit.
// Reset clears the window, coordinates and registers to their defaults.
module diagonal_window_match_counter #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned COORD_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dwmc_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dwmc_pkg::out_word_t                 out_data,
	input  logic                                cfg_wen,
	input  logic [dwmc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [dwmc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import dwmc_pkg::*;

	localparam int unsigned LW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned CB = COORD_BITS;

	logic [6:0]        window_len_q;
	logic [6:0]        match_threshold_q;
	logic [1:0]        compare_mode_q;
	logic [CB-1:0]     pos_a_q;
	logic [CB-1:0]     pos_b_q;
	logic [LW-1:0]     len_eff;
	logic [LW-1:0]     len_new;
	logic              len_wr;
	logic              accept;
	logic              hit;
	logic              busy;
	logic              report;
	logic              rev;
	logic [CB-1:0]     ca;
	logic [CB-1:0]     cb;
	win_ctrl_t         ctrl;

	logic              valid_s1;
	logic [CB-1:0]     ca_s1;
	logic [CB-1:0]     cb_s1;
	logic [LW-1:0]     back_s1;
	logic              rev_s1;
	logic              adv_s1;

	logic              out_valid_q;
	out_word_t         out_data_q;
	logic              out_adv;
	logic [CB-1:0]     ba;
	logic [CB-1:0]     bb;
	logic [CB:0]       ba_p1;
	logic [CB:0]       bb_p1;
	logic [CB:0]       ca_p1;
	logic [CB:0]       cb_p1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WINDOW_LEN_RST;
			match_threshold_q <= MATCH_THRESHOLD_RST;
			compare_mode_q <= MODE_NUC;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_WINDOW_LEN:      window_len_q <= cfg_wdata;
				CFG_MATCH_THRESHOLD: match_threshold_q <= cfg_wdata;
				CFG_COMPARE_MODE:    compare_mode_q <= cfg_wdata[1:0];
				default:             ;
			endcase
		end
	end

	assign len_eff = LW'(eff_len(window_len_q, MAX_WINDOW));
	assign len_new = LW'(eff_len(cfg_wdata, MAX_WINDOW));
	assign len_wr = cfg_wen && (cfg_idx == CFG_WINDOW_LEN);

	// Input handshake: stall during a recount or when the result path is full
	assign out_adv = !out_valid_q || out_ready;
	assign adv_s1 = !valid_s1 || out_adv;
	assign in_ready = !busy && adv_s1;
	assign accept = in_valid && in_ready;

	dwmc_match u_match (
		.sym_a (in_data.sym_a),
		.sym_b (in_data.sym_b),
		.mode  (compare_mode_q),
		.hit   (hit)
	);

	assign ctrl = '{step: accept, clear: in_data.diag_first, hit: hit};

	dwmc_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.len     (len_eff),
		.thr     (match_threshold_q),
		.len_wr  (len_wr),
		.len_new (len_new),
		.busy    (busy),
		.report  (report)
	);

	// Coordinates of this pair: restart on a new diagonal, else continue
	assign rev = (compare_mode_q == MODE_REVCOMP);
	assign ca = in_data.diag_first ? CB'(in_data.start_a) : pos_a_q;
	assign cb = in_data.diag_first ? CB'(in_data.start_b) : pos_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_a_q <= '0;
			pos_b_q <= '0;
		end else if (accept) begin
			pos_a_q <= rev ? ca - CB'(1) : ca + CB'(1);
			pos_b_q <= cb + CB'(1);
		end
	end

	// Result stage: hold the end coordinates and span of a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept && report;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ca_s1 <= ca;
			cb_s1 <= cb;
			back_s1 <= len_eff - LW'(1);
			rev_s1 <= rev;
		end
	end

	// Window begin coordinates and the 1-based offset
	assign ba = rev_s1 ? ca_s1 + CB'(back_s1) : ca_s1 - CB'(back_s1);
	assign bb = cb_s1 - CB'(back_s1);
	assign ba_p1 = {1'b0, ba} + (CB + 1)'(1);
	assign bb_p1 = {1'b0, bb} + (CB + 1)'(1);
	assign ca_p1 = {1'b0, ca_s1} + (CB + 1)'(1);
	assign cb_p1 = {1'b0, cb_s1} + (CB + 1)'(1);

	// Output register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_data_q.a_begin <= OUT_COORD_W'(ba_p1);
			out_data_q.b_begin <= OUT_COORD_W'(bb_p1);
			out_data_q.a_end <= OUT_COORD_W'(ca_p1);
			out_data_q.b_end <= OUT_COORD_W'(cb_p1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A new diagonal restarts the second-sequence coordinate from its start
	a_diag_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.diag_first) |=>
			(pos_b_q == $past(CB'(in_data.start_b) + CB'(1))))
		else $error("second coordinate did not restart on a new diagonal");

endmodule
